### design/matrix3x3_inverse_macros.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// same-cycle implication
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Types and constants of the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package m3i_pkg;

  localparam int ElemW    = 32;
  localparam int FracBits = 16;

  localparam int AdjW = 2 * ElemW + 1;
  localparam int ProdW = 3 * ElemW + 2;
  localparam int DetW = ProdW + 2;

  localparam logic RegTranspose = 1'b0;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [ElemW-1:0] inv00;
    logic signed [ElemW-1:0] inv01;
    logic signed [ElemW-1:0] inv02;
    logic signed [ElemW-1:0] inv10;
    logic signed [ElemW-1:0] inv11;
    logic signed [ElemW-1:0] inv12;
    logic signed [ElemW-1:0] inv20;
    logic signed [ElemW-1:0] inv21;
    logic signed [ElemW-1:0] inv22;
    logic                    singular;
  } out_word_t;

  typedef struct packed {
    logic signed [ElemW-1:0] res;
    logic                    zero;
  } lane_res_t;

endpackage

### design/m3i_cof.sv
// ----------------------------------------------------------------------------
// m3i_cof
// Cofactors and determinant, five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module m3i_cof
  import m3i_pkg::*;
(
  input  logic                    clk_i,
  input  logic [4:0]              en_i,
  input  logic signed [ElemW-1:0] a_i [9],
  output logic signed [AdjW-1:0]  adj_o [9],
  output logic signed [DetW-1:0]  det_o
);

  localparam int W = ElemW;

  localparam logic [3:0] CofIdx [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  logic signed [2*W-1:0]  p_q   [18];
  logic signed [W-1:0]    c1_q  [3];
  logic signed [AdjW-1:0] adj2_q [9];
  logic signed [W-1:0]    c2_q  [3];
  logic signed [2*W:0]    lo_q  [3];
  logic signed [2*W:0]    hi_q  [3];
  logic signed [AdjW-1:0] adj3_q [9];
  logic signed [ProdW-1:0] pr_q [3];
  logic signed [AdjW-1:0] adj4_q [9];
  logic signed [DetW-1:0] det_q;
  logic signed [AdjW-1:0] adj5_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < 9; k++) begin
        p_q[2*k]   <= a_i[CofIdx[k][0]] * a_i[CofIdx[k][1]];
        p_q[2*k+1] <= a_i[CofIdx[k][2]] * a_i[CofIdx[k][3]];
      end
      c1_q[0] <= a_i[0];
      c1_q[1] <= a_i[3];
      c1_q[2] <= a_i[6];
    end
    if (en_i[1]) begin
      for (int k = 0; k < 9; k++) begin
        adj2_q[k] <= $signed({p_q[2*k][2*W-1], p_q[2*k]})
                   - $signed({p_q[2*k+1][2*W-1], p_q[2*k+1]});
      end
      c2_q <= c1_q;
    end
    if (en_i[2]) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= c2_q[j] * $signed({1'b0, adj2_q[j][W-1:0]});
        hi_q[j] <= c2_q[j] * $signed(adj2_q[j][AdjW-1:W]);
      end
      adj3_q <= adj2_q;
    end
    if (en_i[3]) begin
      for (int j = 0; j < 3; j++) begin
        pr_q[j] <= $signed({hi_q[j][2*W], hi_q[j], {W{1'b0}}})
                 + $signed({{(W+1){lo_q[j][2*W]}}, lo_q[j]});
      end
      adj4_q <= adj3_q;
    end
    if (en_i[4]) begin
      det_q <= $signed({{2{pr_q[0][ProdW-1]}}, pr_q[0]})
             + $signed({{2{pr_q[1][ProdW-1]}}, pr_q[1]})
             + $signed({{2{pr_q[2][ProdW-1]}}, pr_q[2]});
      adj5_q <= adj4_q;
    end
  end

  assign adj_o = adj5_q;
  assign det_o = det_q;

endmodule

### design/m3i_lane.sv
// ----------------------------------------------------------------------------
// m3i_lane
// One result element: adjugate entry over determinant, one quotient bit
// per stage, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module m3i_lane
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FracBits
) (
  input  logic                   clk_i,
  input  logic [ElemW+1:0]       en_i,
  input  logic signed [AdjW-1:0] adj_i,
  input  logic signed [DetW-1:0] det_i,
  output lane_res_t              res_o
);

  localparam int W  = ElemW;
  localparam int QW = W - 1;
  localparam int NW = AdjW + 2 * FRAC_BITS;
  localparam int TW = DetW + W - 1;
  localparam int CW = (NW > TW) ? NW : TW;

  logic [NW-1:0]   num1_q;
  logic [DetW-1:0] den1_q;
  logic            neg1_q;
  logic            zero1_q;

  logic [CW-1:0]   rem_q  [W];
  logic [DetW-1:0] den_q  [W];
  logic [QW-1:0]   qb_q   [W];
  logic            ovf_q  [W];
  logic            neg_q  [W];
  logic            zero_q [W];

  logic [AdjW-1:0] adj_mag;
  logic [DetW-1:0] det_mag;
  logic [CW-1:0]   lim;
  lane_res_t       res_q;
  logic [W-1:0]    mag;

  assign adj_mag = adj_i[AdjW-1] ? AdjW'(-adj_i) : AdjW'(adj_i);
  assign det_mag = det_i[DetW-1] ? DetW'(-det_i) : DetW'(det_i);
  assign lim     = {{(CW-DetW){1'b0}}, den1_q} << QW;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num1_q  <= {adj_mag, {(2*FRAC_BITS){1'b0}}};
      den1_q  <= det_mag;
      neg1_q  <= adj_i[AdjW-1] ^ det_i[DetW-1];
      zero1_q <= (det_i == '0);
    end
    if (en_i[1]) begin
      rem_q[0]  <= {{(CW-NW){1'b0}}, num1_q};
      den_q[0]  <= den1_q;
      qb_q[0]   <= '0;
      ovf_q[0]  <= ({{(CW-NW){1'b0}}, num1_q} >= lim);
      neg_q[0]  <= neg1_q;
      zero_q[0] <= zero1_q;
    end
  end

  for (genvar s = 1; s < W; s++) begin : g_step
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = {{(CW-DetW){1'b0}}, den_q[s-1]} << (QW - s);
    assign ge    = (rem_q[s-1] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i[s+1]) begin
        rem_q[s]  <= ge ? (rem_q[s-1] - trial) : rem_q[s-1];
        qb_q[s]   <= qb_q[s-1] | (QW'(ge) << (QW - s));
        den_q[s]  <= den_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  assign mag = {1'b0, qb_q[W-1]};

  always_ff @(posedge clk_i) begin
    if (en_i[W+1]) begin
      if (ovf_q[W-1]) begin
        res_q.res <= neg_q[W-1] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
      end else begin
        res_q.res <= neg_q[W-1] ? -mag : mag;
      end
      res_q.zero <= zero_q[W-1];
    end
  end

  assign res_o = res_q;

endmodule

### design/m3i_merge.sv
// ----------------------------------------------------------------------------
// m3i_merge
// Gather the nine lane results into the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module m3i_merge
  import m3i_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  logic      transpose_i,
  input  lane_res_t lane_i [9],
  output out_word_t word_o
);

  out_word_t               word_q;
  out_word_t               word_d;
  logic signed [ElemW-1:0] e [9];
  logic                    sing;

  always_comb begin
    sing = lane_i[0].zero;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r*3+c] = sing ? '0 : (transpose_i ? lane_i[c*3+r].res : lane_i[r*3+c].res);
      end
    end
    word_d.inv00    = e[0];
    word_d.inv01    = e[1];
    word_d.inv02    = e[2];
    word_d.inv10    = e[3];
    word_d.inv11    = e[4];
    word_d.inv12    = e[5];
    word_d.inv20    = e[6];
    word_d.inv21    = e[7];
    word_d.inv22    = e[8];
    word_d.singular = sing;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

### design/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined 3x3 Q16.16 matrix inverse by the adjugate.
// ----------------------------------------------------------------------------
// One matrix per input word on in_word_i (valid/ready), one result word on
// out_word_o (valid/ready): nine saturated Q16.16 elements and a singular
// flag, all elements zero when the determinant is zero.
// The pipe has five stages for the cofactors and determinant, ElemW + 2
// in each of nine divider lanes (one quotient bit per stage) and one for
// the output register.
// Throughput is one word per cycle; every stage holds only when the stage
// after it is full and held, so bubbles are squeezed out and input is taken
// while a finished word waits at the output.
// When the receiver stalls the output word holds; the pipe fills behind it
// and then in_ready_o drops.
// Reset empties the pipe and clears transpose_output (APB address 0, bit 0).
// Write transpose_output only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3x3_inverse_macros.svh"

module matrix3x3_inverse
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LaneLat = ElemW + 2;
  localparam int Lat     = 5 + LaneLat + 1;

  logic [Lat-1:0]          vld_q;
  logic [Lat-1:0]          vld_d;
  logic [Lat-1:0]          en;
  logic                    tr_q;
  logic signed [ElemW-1:0] a [9];
  logic signed [AdjW-1:0]  adj [9];
  logic signed [DetW-1:0]  det;
  lane_res_t               lane_res [9];

  always_comb begin
    en[Lat-1] = !vld_q[Lat-1] || out_ready_i;
    for (int s = Lat - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < Lat; s++) begin
      vld_d[s] = en[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tr_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (psel && penable && pwrite && (paddr[2] == RegTranspose)) begin
        tr_q <= pwdata[0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTranspose) ? {31'd0, tr_q} : 32'd0;

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[Lat-1];

  assign a[0] = in_word_i.m00;
  assign a[1] = in_word_i.m01;
  assign a[2] = in_word_i.m02;
  assign a[3] = in_word_i.m10;
  assign a[4] = in_word_i.m11;
  assign a[5] = in_word_i.m12;
  assign a[6] = in_word_i.m20;
  assign a[7] = in_word_i.m21;
  assign a[8] = in_word_i.m22;

  m3i_cof u_cof (
    .clk_i (clk_i),
    .en_i  (en[4:0]),
    .a_i   (a),
    .adj_o (adj),
    .det_o (det)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en[5+LaneLat-1:5]),
      .adj_i (adj[k]),
      .det_i (det),
      .res_o (lane_res[k])
    );
  end

  m3i_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en[Lat-1]),
    .transpose_i (tr_q),
    .lane_i      (lane_res),
    .word_o      (out_word_o)
  );

  `M3I_ASSERT_NOW(a_sing_zero, out_valid_o && out_word_o.singular, (out_word_o.inv00 == 0) && (out_word_o.inv11 == 0) && (out_word_o.inv22 == 0), "singular word with nonzero elements")
  `M3I_ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, vld_q[0], "accepted word lost at first stage")
  `M3I_ASSERT_NOW(a_empty_takes, !vld_q[0], in_ready_o, "empty first stage refuses input")

endmodule

### sim/tb_matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Self-checking bench for the pipelined 3x3 Q16.16 matrix inverse: directed
// matrices (identity, extremes, singular, saturating), then random matrices
// under both transpose settings, with random idling on both sides. Results
// are compared with a wide-integer adjugate inverse or a given word.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;
  import m3i_pkg::*;

  localparam int NumRandom  = 300;
  localparam int NumPhases  = 6;
  localparam int DrainWait  = 60;
  localparam int StallLimit = 4000;
  localparam logic [2:0] AddrTranspose = 3'd0;
  localparam logic [2:0] AddrBeyond    = 3'd4;
  localparam logic signed [31:0] One   = 32'sh0001_0000;

  typedef struct {
    in_word_t  mat;
    bit        typed;
    out_word_t res;
  } row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_word_t    in_word_i;
  out_word_t   out_word_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  out_word_t   pending_inv[$];
  row_t        dir_rows[$];
  bit          transpose_mode;
  bit          quiet;
  int          mismatches, words_out, singular_seen, stall_cnt, idle_cycles;

  matrix3x3_inverse i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] div_elem(logic signed [255:0] adj,
                                           logic signed [255:0] det);
    logic [255:0] num, den, q;
    bit neg;
    neg = adj[255] ^ det[255];
    num = (adj[255] ? -adj : adj) << (2 * FracBits);
    den = det[255] ? -det : det;
    q   = num / den;
    if (!neg && q >= 256'h8000_0000) return 32'h7FFF_FFFF;
    if (neg && q > 256'h8000_0000) return 32'h8000_0000;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic out_word_t invert(in_word_t w, bit tr);
    logic signed [255:0] a[9], adj[9], det;
    logic [31:0] e[9];
    out_word_t r;
    a[0] = w.m00; a[1] = w.m01; a[2] = w.m02;
    a[3] = w.m10; a[4] = w.m11; a[5] = w.m12;
    a[6] = w.m20; a[7] = w.m21; a[8] = w.m22;
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[3] * adj[1] + a[6] * adj[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++)
      e[i] = div_elem(adj[tr ? (i % 3) * 3 + i / 3 : i], det);
    r = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b0};
    return r;
  endfunction

  function automatic in_word_t mat9(logic [31:0] a0, a1, a2, a3, a4, a5, a6, a7, a8);
    return {a0, a1, a2, a3, a4, a5, a6, a7, a8};
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3, 4:    return $urandom;
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
    endcase
  endfunction

  function automatic in_word_t rand_matrix();
    logic [31:0] e[9];
    for (int i = 0; i < 9; i++) e[i] = rand_elem();
    case ($urandom_range(0, 9))
      0: begin
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end
      1: begin
        e[3] = '0; e[4] = '0; e[5] = '0;
      end
      2: for (int i = 0; i < 9; i++) if (i % 4 != 0) e[i] = '0;
      default: ;
    endcase
    return mat9(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrTranspose) transpose_mode = data[0];
  endtask

  task automatic apb_check();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= AddrTranspose;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== transpose_mode) report("transpose_output read", prdata, transpose_mode);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic settle();
    while (pending_inv.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic send(in_word_t w, bit typed, out_word_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_inv.push_back(typed ? res : invert(w, transpose_mode));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb_matrix3x3_inverse: FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        words_out++;
        if (pending_inv.size() == 0) begin
          report("unexpected word", out_word_o[31:0], '0);
        end else begin
          out_word_t want;
          want = pending_inv.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_word_o[1 + 32 * (8 - k) +: 32] !== want[1 + 32 * (8 - k) +: 32])
              report($sformatf("inv%0d%0d", k / 3, k % 3),
                     out_word_o[1 + 32 * (8 - k) +: 32], want[1 + 32 * (8 - k) +: 32]);
          if (out_word_o.singular !== want.singular)
            report("singular", out_word_o.singular, want.singular);
          if (want.singular) singular_seen++;
        end
      end
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_cnt   <= $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    out_word_t id_res, sat_pos, sat_neg, sing;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_word_i = '0; out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    transpose_mode = 1'b0; quiet = 1'b0;
    mismatches = 0; words_out = 0; singular_seen = 0; stall_cnt = 0; idle_cycles = 0;

    sing    = '0; sing.singular = 1'b1;
    id_res  = {One, 32'h0, 32'h0, 32'h0, One, 32'h0, 32'h0, 32'h0, One, 1'b0};
    sat_pos = {32'h7FFF_FFFF, 96'h0, 32'h7FFF_FFFF, 96'h0, 32'h7FFF_FFFF, 1'b0};
    sat_neg = {32'h8000_0000, 96'h0, 32'h8000_0000, 96'h0, 32'h8000_0000, 1'b0};
    dir_rows.push_back('{'0, 1, sing});
    dir_rows.push_back('{mat9(One, 0, 0, 0, One, 0, 0, 0, One), 1, id_res});
    dir_rows.push_back('{mat9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1, sat_pos});
    dir_rows.push_back('{mat9(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1, sat_neg});
    dir_rows.push_back('{{9{32'h7FFF_FFFF}}, 1, sing});
    dir_rows.push_back('{{9{32'h8000_0000}}, 1, sing});
    dir_rows.push_back('{mat9(1, 2, 3, 4, 5, 6, 7, 8, 9) <<< 16, 1, sing});
    dir_rows.push_back('{mat9(2 * One, 0, 0, 0, 2 * One, 0, 0, 0, 2 * One), 0, '0});
    dir_rows.push_back('{mat9(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, One), 0, '0});
    dir_rows.push_back('{mat9(One, 2 * One, 0, 0, One, 3 * One, 4 * One, 0, One), 0, '0});
    dir_rows.push_back('{mat9(32'h7FFF_FFFF, 1, 32'h8000_0000, 5, 32'h7FFF_FFFF, 3,
                              32'h8000_0000, 7, 32'h7FFF_FFFF), 0, '0});
    dir_rows.push_back('{mat9(-One, 0, 0, 0, 0, -One, 0, -One, 0), 0, '0});
    dir_rows.push_back('{{9{32'hFFFF_FFFF}}, 1, sing});
    dir_rows.push_back('{mat9(3, 32'hFFFF_0001, 7, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 11,
                              32'h5555_5555, 32'hAAAA_AAAA, 13), 0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check();

    foreach (dir_rows[i]) send(dir_rows[i].mat, dir_rows[i].typed, dir_rows[i].res);
    in_valid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p % 3)
        0:       apb_write(AddrTranspose, 32'h0000_0001);
        1:       apb_write(AddrTranspose, 32'hFFFF_FFFE);
        default: apb_write(AddrTranspose, 32'hFFFF_FFFF);
      endcase
      if (p == 2) apb_write(AddrBeyond, 32'h0000_0000);
      apb_check();
      quiet = (p == NumPhases - 1);
      for (int n = 0; n < NumRandom; n++) send(rand_matrix(), 0, '0);
      in_valid_i <= 1'b0;
    end

    settle();
    $display("covered %0d result words, %0d singular, both transpose settings",
             words_out, singular_seen);
    $display("%0d mismatches reported", mismatches);
    if (mismatches == 0 && pending_inv.size() == 0) begin
      $display("tb_matrix3x3_inverse: PASS");
    end else begin
      $display("tb_matrix3x3_inverse: FAIL");
    end
    $finish;
  end
endmodule
